// File: hw/rtl/vlt_pkg.sv
`timescale 1ns / 1ps

package vlt_pkg;

  // Default geometry
  localparam int GRID_DIM_DEF  = 16;
  localparam int FRAC_BITS_DEF = 12;

  // Fixed field widths
  localparam int IN_W  = 16;
  localparam int VOX_W = 4;

  // Axis codes
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  // Per-axis step direction codes
  localparam logic [1:0] SIGN_NONE = 2'd0;
  localparam logic [1:0] SIGN_UP   = 2'd1;
  localparam logic [1:0] SIGN_DOWN = 2'd2;

  // Cross products dist[a] * delta[b], one per ordered axis pair
  localparam int PAIR_W    = 3;
  localparam int NUM_PAIRS = 6;
  localparam logic [PAIR_W-1:0] PAIR_XY = 3'd0;
  localparam logic [PAIR_W-1:0] PAIR_YX = 3'd1;
  localparam logic [PAIR_W-1:0] PAIR_XZ = 3'd2;
  localparam logic [PAIR_W-1:0] PAIR_ZX = 3'd3;
  localparam logic [PAIR_W-1:0] PAIR_YZ = 3'd4;
  localparam logic [PAIR_W-1:0] PAIR_ZY = 3'd5;

  typedef struct packed {
    logic [IN_W-1:0] start_x;
    logic [IN_W-1:0] start_y;
    logic [IN_W-1:0] start_z;
    logic [IN_W-1:0] end_x;
    logic [IN_W-1:0] end_y;
    logic [IN_W-1:0] end_z;
  } in_item_t;

  typedef struct packed {
    logic [VOX_W-1:0] voxel_x;
    logic [VOX_W-1:0] voxel_y;
    logic [VOX_W-1:0] voxel_z;
    logic             last;
    logic             cut_short;
  } out_item_t;

  // Request or response tag of the shared multiplier
  typedef struct packed {
    logic              vld;
    logic [PAIR_W-1:0] tag;
  } mul_ctl_t;

  // Distance axis of a pair
  function automatic logic [1:0] pair_a(input logic [PAIR_W-1:0] p);
    logic [1:0] r;
    case (p)
      PAIR_XY, PAIR_XZ: r = AXIS_X;
      PAIR_YX, PAIR_YZ: r = AXIS_Y;
      PAIR_ZX, PAIR_ZY: r = AXIS_Z;
      default:          r = AXIS_X;
    endcase
    return r;
  endfunction

  // Delta axis of a pair
  function automatic logic [1:0] pair_b(input logic [PAIR_W-1:0] p);
    logic [1:0] r;
    case (p)
      PAIR_YX, PAIR_ZX: r = AXIS_X;
      PAIR_XY, PAIR_ZY: r = AXIS_Y;
      PAIR_XZ, PAIR_YZ: r = AXIS_Z;
      default:          r = AXIS_X;
    endcase
    return r;
  endfunction

endpackage

// File: hw/rtl/vlt_mult.sv
`timescale 1ns / 1ps

module vlt_mult import vlt_pkg::*; #(
  parameter int A_W = 13,
  parameter int B_W = 16,
  parameter int P_W = 35
) (
  input  logic           clk,
  input  logic           rst_n,
  input  mul_ctl_t       req,
  input  logic [A_W-1:0] a,
  input  logic [B_W-1:0] b,
  output mul_ctl_t       rsp,
  output logic [P_W-1:0] prod
);

  logic [A_W+B_W-1:0] full;

  // Form one product per cycle
  assign full = a * b;

  // Register product and tag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rsp.vld <= 1'b0;
    end else begin
      rsp.vld <= req.vld;
    end
    rsp.tag <= req.tag;
    prod    <= P_W'(full);
  end

endmodule

// File: hw/rtl/vlt_axis_pick.sv
`timescale 1ns / 1ps

module vlt_axis_pick import vlt_pkg::*; #(
  parameter int P_W = 35
) (
  input  logic [P_W-1:0] prod [NUM_PAIRS],
  input  logic [2:0]     moving,
  output logic [1:0]     axis
);

  logic e_xy, e_xz, e_yz;

  // Axis a is earlier than b: a moves and (b is still or a's time is smaller)
  assign e_xy = moving[0] && (!moving[1] || (prod[PAIR_XY] < prod[PAIR_YX]));
  assign e_xz = moving[0] && (!moving[2] || (prod[PAIR_XZ] < prod[PAIR_ZX]));
  assign e_yz = moving[1] && (!moving[2] || (prod[PAIR_YZ] < prod[PAIR_ZY]));

  // Pick the axis that reaches its boundary first; ties fall to z, then y
  always_comb begin
    if (e_xy) begin
      axis = e_xz ? AXIS_X : AXIS_Z;
    end else begin
      axis = e_yz ? AXIS_Y : AXIS_Z;
    end
  end

endmodule

// File: hw/rtl/voxel_line_traversal.sv
`timescale 1ns / 1ps

// Walks a segment through a GRID_DIM^3 voxel grid and returns every voxel it
// crosses, start voxel first, end voxel last (marked by last). Coordinates are
// unsigned fixed point with FRAC_BITS fraction bits. One item is taken at a
// time: after acceptance the shared multiplier forms the six cross products
// of boundary distance and axis delta, one per cycle, into its output
// register, then the walk emits one voxel per cycle while out_ready
// stays high, updating the products by addition only. An item yields at
// most 3*GRID_DIM-2 voxels: a run that has not reached the end voxel after
// that many voxels ends there with last and cut_short set. Indices past a
// grid edge wrap; points beyond the grid saturate to the top voxel.
// in_ready is high only while no walk is active.
module voxel_line_traversal import vlt_pkg::*; #(
  parameter int GRID_DIM  = GRID_DIM_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int MAX_VOX = 1 + 3 * (GRID_DIM - 1);
  localparam int IDX_W   = $clog2(GRID_DIM);
  localparam int CNT_W   = $clog2(MAX_VOX);
  localparam int D0_W    = FRAC_BITS + 1;
  localparam int DIST_W  = FRAC_BITS + CNT_W + 1;
  localparam int PROD_W  = DIST_W + IN_W;

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_RUN} state_t;

  state_t            state_r;
  logic [IDX_W-1:0]  cur_r [3];
  logic [IDX_W-1:0]  tgt_r [3];
  logic [1:0]        sg_r  [3];
  logic [IN_W-1:0]   dl_r  [3];
  logic [D0_W-1:0]   d0_r  [3];
  logic [PROD_W-1:0] prod_r [NUM_PAIRS];
  logic [CNT_W-1:0]  cnt_r;
  logic [PAIR_W-1:0] mul_cnt_r;
  logic              out_valid_r;
  out_item_t         out_data_r;

  logic [IN_W-1:0]   p0 [3];
  logic [IN_W-1:0]   p1 [3];
  logic [IDX_W-1:0]  c0 [3];
  logic [IDX_W-1:0]  c1 [3];
  logic [1:0]        sg [3];
  logic [IN_W-1:0]   dl [3];
  logic [D0_W-1:0]   d0 [3];
  logic [IDX_W-1:0]  cur_nxt [3];
  logic [PROD_W-1:0] prod_nxt [NUM_PAIRS];
  logic [PROD_W-1:0] inc [3];
  logic [2:0]        moving;
  logic [1:0]        axis;
  logic              at_tgt;
  logic              at_limit;
  logic              is_last;
  logic              out_free;
  logic              emit;
  mul_ctl_t          mul_req;
  mul_ctl_t          mul_rsp;
  logic [PROD_W-1:0] mul_prod;

  assign p0[0] = in_data.start_x;
  assign p0[1] = in_data.start_y;
  assign p0[2] = in_data.start_z;
  assign p1[0] = in_data.end_x;
  assign p1[1] = in_data.end_y;
  assign p1[2] = in_data.end_z;

  // Per-axis setup: voxel indices, direction, delta and first boundary distance
  always_comb begin
    logic [IN_W-1:0] raw0, raw1;
    logic [D0_W-1:0] frac;
    for (int a = 0; a < 3; a++) begin
      raw0  = p0[a] >> FRAC_BITS;
      raw1  = p1[a] >> FRAC_BITS;
      c0[a] = (raw0 >= IN_W'(GRID_DIM - 1)) ? IDX_W'(GRID_DIM - 1) : IDX_W'(raw0);
      c1[a] = (raw1 >= IN_W'(GRID_DIM - 1)) ? IDX_W'(GRID_DIM - 1) : IDX_W'(raw1);
      frac  = D0_W'(p0[a]) & ((D0_W'(1) << FRAC_BITS) - D0_W'(1));
      if (p1[a] > p0[a]) begin
        sg[a] = SIGN_UP;
        dl[a] = p1[a] - p0[a];
        d0[a] = (D0_W'(1) << FRAC_BITS) - frac;
      end else if (p1[a] < p0[a]) begin
        sg[a] = SIGN_DOWN;
        dl[a] = p0[a] - p1[a];
        d0[a] = frac;
      end else begin
        sg[a] = SIGN_NONE;
        dl[a] = '0;
        d0[a] = '0;
      end
    end
  end

  // Issue one cross product per cycle to the shared multiplier
  assign mul_req.vld = (state_r == S_MUL) && (mul_cnt_r < PAIR_W'(NUM_PAIRS));
  assign mul_req.tag = mul_cnt_r;

  vlt_mult #(
    .A_W (D0_W),
    .B_W (IN_W),
    .P_W (PROD_W)
  ) u_mult (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .a     (d0_r[pair_a(mul_cnt_r)]),
    .b     (dl_r[pair_b(mul_cnt_r)]),
    .rsp   (mul_rsp),
    .prod  (mul_prod)
  );

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      moving[a] = (sg_r[a] != SIGN_NONE);
      inc[a]    = PROD_W'(dl_r[a]) << FRAC_BITS;
    end
  end

  vlt_axis_pick #(
    .P_W (PROD_W)
  ) u_pick (
    .prod   (prod_r),
    .moving (moving),
    .axis   (axis)
  );

  // End-of-run detection
  assign at_tgt   = (cur_r[0] == tgt_r[0]) && (cur_r[1] == tgt_r[1]) &&
                    (cur_r[2] == tgt_r[2]);
  assign at_limit = (cnt_r == CNT_W'(MAX_VOX - 1));
  assign is_last  = at_tgt || at_limit;
  assign out_free = !out_valid_r || out_ready;
  assign emit     = (state_r == S_RUN) && out_free;

  // Advance the chosen axis, wrapping at the grid edges
  always_comb begin
    logic [IDX_W:0] up;
    for (int a = 0; a < 3; a++) begin
      up         = {1'b0, cur_r[a]} + (IDX_W+1)'(1);
      cur_nxt[a] = cur_r[a];
      if (axis == 2'(a)) begin
        case (sg_r[a])
          SIGN_UP:   cur_nxt[a] = (up >= (IDX_W+1)'(GRID_DIM)) ? '0 : IDX_W'(up);
          SIGN_DOWN: cur_nxt[a] = (cur_r[a] == '0) ? IDX_W'(GRID_DIM - 1)
                                                   : cur_r[a] - IDX_W'(1);
          default:   cur_nxt[a] = cur_r[a];
        endcase
      end
    end
  end

  // Add one cell to the chosen axis distance by bumping its products
  always_comb begin
    for (int p = 0; p < NUM_PAIRS; p++) begin
      prod_nxt[p] = prod_r[p];
      if ((pair_a(PAIR_W'(p)) == axis) && moving[axis]) begin
        prod_nxt[p] = prod_r[p] + inc[pair_b(PAIR_W'(p))];
      end
    end
  end

  // Sequencer, walk state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      mul_cnt_r   <= '0;
      cnt_r       <= '0;
    end else begin
      if (out_valid_r && out_ready && !emit) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            for (int a = 0; a < 3; a++) begin
              cur_r[a] <= c0[a];
              tgt_r[a] <= c1[a];
              sg_r[a]  <= sg[a];
              dl_r[a]  <= dl[a];
              d0_r[a]  <= d0[a];
            end
            mul_cnt_r <= '0;
            state_r   <= S_MUL;
          end
        end
        S_MUL: begin
          if (mul_req.vld) begin
            mul_cnt_r <= mul_cnt_r + PAIR_W'(1);
          end
          if (mul_rsp.vld) begin
            prod_r[mul_rsp.tag] <= mul_prod;
            if (mul_rsp.tag == PAIR_W'(NUM_PAIRS - 1)) begin
              cnt_r   <= '0;
              state_r <= S_RUN;
            end
          end
        end
        S_RUN: begin
          if (emit) begin
            out_valid_r          <= 1'b1;
            out_data_r.voxel_x   <= VOX_W'(cur_r[0]);
            out_data_r.voxel_y   <= VOX_W'(cur_r[1]);
            out_data_r.voxel_z   <= VOX_W'(cur_r[2]);
            out_data_r.last      <= is_last;
            out_data_r.cut_short <= !at_tgt && at_limit;
            if (is_last) begin
              state_r <= S_IDLE;
            end else begin
              cnt_r <= cnt_r + CNT_W'(1);
              for (int a = 0; a < 3; a++) begin
                cur_r[a] <= cur_nxt[a];
              end
              for (int p = 0; p < NUM_PAIRS; p++) begin
                prod_r[p] <= prod_nxt[p];
              end
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The step counter never passes the run limit
  a_cnt_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN) |-> (cnt_r <= CNT_W'(MAX_VOX - 1)))
    else $error("step count past run limit");

  // A cut-short item is always the last of its run
  a_cut_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!out_data_r.cut_short || out_data_r.last))
    else $error("cut_short without last");

  // Emitting the last voxel returns the walk to idle
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && is_last) |=> (state_r == S_IDLE))
    else $error("walk continued after last voxel");

  // Multiplier results arrive only during product setup
  a_mul_phase: assert property (@(posedge clk) disable iff (!rst_n)
    mul_rsp.vld |-> (state_r == S_MUL))
    else $error("multiplier result outside setup");

endmodule

// File: test/voxel_line_traversal_test.sv
`timescale 1ns / 1ps

module voxel_line_traversal_test;
  import vlt_pkg::*;

  localparam int ONE_CELL    = 1 << FRAC_BITS_DEF;
  localparam int MAX_VOXELS  = 3 * GRID_DIM_DEF - 2;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE      = 64;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  in_item_t  pending_segments [$];
  out_item_t expected_voxels [$];

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int mismatches    = 0;
  int cycle_count   = 0;

  // Walk state of the predictor, one entry per axis
  logic [VOX_W-1:0] walk_cur   [3];
  logic [VOX_W-1:0] walk_tgt   [3];
  logic [31:0]      walk_dist  [3];
  logic [31:0]      walk_delta [3];
  logic [1:0]       walk_dir   [3];

  voxel_line_traversal uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Append one segment to the send queue
  function automatic void queue_segment(input in_item_t s);
    pending_segments.insert(pending_segments.size(), s);
  endfunction

  // Append one voxel to the expected results
  function automatic void expect_voxel(input out_item_t v);
    expected_voxels.insert(expected_voxels.size(), v);
  endfunction

  // True when axis a reaches its next boundary strictly before axis b;
  // a still axis is infinitely far
  function automatic bit sooner(input logic [1:0] a, input logic [1:0] b);
    if (walk_delta[a] == 0) return 1'b0;
    if (walk_delta[b] == 0) return 1'b1;
    return (64'(walk_dist[a]) * 64'(walk_delta[b])) <
           (64'(walk_dist[b]) * 64'(walk_delta[a]));
  endfunction

  // Walk one segment and queue every voxel it crosses
  function automatic void walk_segment(input in_item_t seg);
    logic [IN_W-1:0] p0 [3];
    logic [IN_W-1:0] p1 [3];
    logic [31:0]     frac;
    logic [1:0]      ax;
    int              count;
    bit              cut;
    out_item_t       vox;
    p0[0] = seg.start_x; p0[1] = seg.start_y; p0[2] = seg.start_z;
    p1[0] = seg.end_x;   p1[1] = seg.end_y;   p1[2] = seg.end_z;
    for (int a = 0; a < 3; a++) begin
      // 4 integer bits never exceed the grid, so the cell is the top nibble
      walk_cur[a] = p0[a][IN_W-1 -: VOX_W];
      walk_tgt[a] = p1[a][IN_W-1 -: VOX_W];
      frac = 32'(p0[a]) & 32'(ONE_CELL - 1);
      if (p1[a] > p0[a]) begin
        walk_dir[a]   = SIGN_UP;
        walk_delta[a] = 32'(p1[a] - p0[a]);
        walk_dist[a]  = 32'(ONE_CELL) - frac;
      end else if (p1[a] < p0[a]) begin
        walk_dir[a]   = SIGN_DOWN;
        walk_delta[a] = 32'(p0[a] - p1[a]);
        walk_dist[a]  = frac;
      end else begin
        walk_dir[a]   = SIGN_NONE;
        walk_delta[a] = '0;
        walk_dist[a]  = '0;
      end
    end
    vox = '{walk_cur[0], walk_cur[1], walk_cur[2], 1'b0, 1'b0};
    count = 1;
    cut = 1'b0;
    while (walk_cur[0] != walk_tgt[0] || walk_cur[1] != walk_tgt[1] ||
           walk_cur[2] != walk_tgt[2]) begin
      if (count >= MAX_VOXELS) begin
        cut = 1'b1;
        break;
      end
      // Pick the earliest axis; z wins ties with x and y, y wins over x
      if (sooner(AXIS_X, AXIS_Y))
        ax = sooner(AXIS_X, AXIS_Z) ? AXIS_X : AXIS_Z;
      else
        ax = sooner(AXIS_Y, AXIS_Z) ? AXIS_Y : AXIS_Z;
      // Step with wrap at the grid edges
      if (walk_dir[ax] == SIGN_UP) begin
        walk_cur[ax]  = walk_cur[ax] + 1'b1;
        walk_dist[ax] = walk_dist[ax] + ONE_CELL;
      end else if (walk_dir[ax] == SIGN_DOWN) begin
        walk_cur[ax]  = walk_cur[ax] - 1'b1;
        walk_dist[ax] = walk_dist[ax] + ONE_CELL;
      end
      expect_voxel(vox);
      vox = '{walk_cur[0], walk_cur[1], walk_cur[2], 1'b0, 1'b0};
      count++;
    end
    vox.last      = 1'b1;
    vox.cut_short = cut;
    expect_voxel(vox);
  endfunction

  function automatic in_item_t make_segment(input int sx, input int sy, input int sz,
                                            input int ex, input int ey, input int ez);
    in_item_t s;
    s = '{16'(sx), 16'(sy), 16'(sz), 16'(ex), 16'(ey), 16'(ez)};
    return s;
  endfunction

  function automatic int near_point(input int p);
    int q;
    q = p + $urandom_range(0, 6 * ONE_CELL) - 3 * ONE_CELL;
    if (q < 0) q = 0;
    if (q > 65535) q = 65535;
    return q;
  endfunction

  // Mostly short segments, some long ones, some on boundaries, some still axes
  function automatic in_item_t random_segment();
    int       kind;
    int       p [6];
    in_item_t s;
    kind = $urandom_range(0, 9);
    for (int a = 0; a < 3; a++) begin
      if (kind == 8) begin
        p[a]     = $urandom_range(0, 31) * (ONE_CELL / 2);
        p[a + 3] = $urandom_range(0, 31) * (ONE_CELL / 2);
      end else begin
        p[a]     = $urandom_range(0, 65535);
        p[a + 3] = (kind <= 5) ? near_point(p[a]) : $urandom_range(0, 65535);
      end
      if (kind == 9 && $urandom_range(0, 1) == 1) p[a + 3] = p[a];
    end
    s = make_segment(p[0], p[1], p[2], p[3], p[4], p[5]);
    return s;
  endfunction

  // Drive segments; predict each one as it is accepted
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) walk_segment(in_data);
      if (!in_valid || in_ready) begin
        if (pending_segments.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_data  <= pending_segments.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Stall the result channel at random
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Check each accepted voxel against the oldest expectation
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (expected_voxels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected voxel (%0d,%0d,%0d) last=%0b cut=%0b",
                   out_data.voxel_x, out_data.voxel_y, out_data.voxel_z,
                   out_data.last, out_data.cut_short);
      end else begin
        want = expected_voxels.pop_front();
        if (out_data.voxel_x !== want.voxel_x || out_data.voxel_y !== want.voxel_y ||
            out_data.voxel_z !== want.voxel_z || out_data.last !== want.last ||
            out_data.cut_short !== want.cut_short) begin
          mismatches++;
          if (mismatches <= 10)
            $display("voxel mismatch: expected (%0d,%0d,%0d) last=%0b cut=%0b, %s",
                     want.voxel_x, want.voxel_y, want.voxel_z, want.last,
                     want.cut_short,
                     $sformatf("got (%0d,%0d,%0d) last=%0b cut=%0b",
                               out_data.voxel_x, out_data.voxel_y, out_data.voxel_z,
                               out_data.last, out_data.cut_short));
        end
      end
    end
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 70; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 70; end
        default: begin send_idle_pct = 17; stall_pct = 17; end
      endcase

      if (phase == 0) begin
        // Field extremes, single voxel, full diagonals, single axes
        queue_segment(make_segment(0, 0, 0, 0, 0, 0));
        queue_segment(make_segment('hFFFF, 'hFFFF, 'hFFFF,
                                   'hFFFF, 'hFFFF, 'hFFFF));
        queue_segment(make_segment('h1100, 'h2200, 'h3300,
                                   'h1F00, 'h2010, 'h3FFF));
        queue_segment(make_segment(0, 0, 0, 'hFFFF, 'hFFFF, 'hFFFF));
        queue_segment(make_segment('hFFFF, 'hFFFF, 'hFFFF, 0, 0, 0));
        queue_segment(make_segment(0, 'h4321, 'h9876, 'hFFFF, 'h4321, 'h9876));
        queue_segment(make_segment('h2345, 'hFFFF, 'h6789, 'h2345, 0, 'h6789));
        queue_segment(make_segment('h5000, 'h5000, 'h0800, 'h5000, 'h5000, 'hF800));
        // Start on a boundary moving down: that axis steps at once
        queue_segment(make_segment('h3000, 'h7777, 'h1111, 'h0800, 'h7777, 'h1111));
        queue_segment(make_segment('h4000, 'h5000, 'h6000, 'h1000, 'h2800, 'h0400));
        // Exact ties between axis pairs and all three
        queue_segment(make_segment('h0800, 'h0800, 'h5555, 'h3800, 'h3800, 'h5555));
        queue_segment(make_segment('h0800, 'h1234, 'h0800, 'h3800, 'h1234, 'h3800));
        queue_segment(make_segment('h9ABC, 'h0800, 'h0800, 'h9ABC, 'h3800, 'h3800));
        queue_segment(make_segment('h0800, 'h0800, 'h0800, 'h3800, 'h3800, 'h3800));
        queue_segment(make_segment('hC800, 'hC800, 'hC800, 'h9800, 'h9800, 'h9800));
        // Tie on the end boundary overshoots: the step limit cuts the run
        queue_segment(make_segment('h1800, 'h7000, 'h1800, 'h2000, 'h7000, 'h1000));
        queue_segment(make_segment('h3333, 'h1800, 'h1800, 'h3333, 'h2000, 'h1000));
        queue_segment(make_segment('h1800, 'h1800, 'h4000, 'h1000, 'h2000, 'h4000));
        // Alternating bits, fraction extremes, tiny moves
        queue_segment(make_segment('hAAAA, 'h5555, 'hAAAA, 'h5555, 'hAAAA, 'h5555));
        queue_segment(make_segment('h0FFF, 'hF001, 'h0FFF, 'hF001, 'h0FFF, 'hF001));
        queue_segment(make_segment('h0001, 'h1000, 'h0FFF, 0, 'h0FFF, 'h1000));
        queue_segment(make_segment('hFFFF, 'hFFFF, 'h8000, 'hF000, 'hEFFF, 'h8000));

        // Hold off until the directed segments have fully drained
        do @(negedge clk);
        while (pending_segments.size() > 0 || in_valid || expected_voxels.size() > 0);
      end

      for (int i = 0; i < 27; i++) queue_segment(random_segment());

      do @(negedge clk);
      while (pending_segments.size() > 0 || in_valid || expected_voxels.size() > 0);
    end

    // Let any stray output show up before the verdict
    repeat (SETTLE) @(negedge clk);

    if (mismatches == 0 && expected_voxels.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/vlt_pkg.sv
hw/rtl/vlt_mult.sv
hw/rtl/vlt_axis_pick.sv
hw/rtl/voxel_line_traversal.sv
test/voxel_line_traversal_test.sv
